// ===== src/tftp_block_sender_control_top_assert.svh =====
// Assertion macros used by the checker file of the TFTP block sender.
// No dependencies.
`ifndef TFTP_BLOCK_SENDER_CONTROL_TOP_ASSERT_SVH
`define TFTP_BLOCK_SENDER_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/tbsc_pkg.sv =====
// Types and constants of the TFTP block sender control.
// No dependencies.
package tbsc_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int IDX_W           = 23;
    localparam int TMO_W           = 16;
    localparam int PROD_W          = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [15:0] BN_LAST   = 16'd65534;
    localparam logic [15:0] BN_FIRST  = 16'd1;
    localparam logic [15:0] TMO_MAX   = 16'hFFFF;

    // receive event codes
    localparam logic [2:0] FN_START   = 3'd0;
    localparam logic [2:0] FN_ACK     = 3'd1;
    localparam logic [2:0] FN_PEERERR = 3'd2;
    localparam logic [2:0] FN_TIMEOUT = 3'd3;
    localparam logic [2:0] FN_RXFAIL  = 3'd4;

    // command status codes
    localparam logic [2:0] ST_SEND     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_TIMEDOUT = 3'd2;
    localparam logic [2:0] ST_PEERERR  = 3'd3;
    localparam logic [2:0] ST_RXFAIL   = 3'd4;
    localparam logic [2:0] ST_INACTIVE = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_PORT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] ack_block;
        logic [15:0] source_port;
        logic [15:0] peer_error_code;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] send_block_number;
        logic [31:0] byte_offset;
        logic [9:0]  byte_count;
        logic        final_block;
        logic [15:0] reported_error;
    } t_out;

endpackage

// ===== src/tftp_block_sender_control_top.sv =====
// Stop-and-wait TFTP data sender control: one command item per receive event item.
// Depends on tbsc_pkg.
//
//  channel   direction  handshake           payload
//  in        input      i_valid / o_stall   i_data (tbsc_pkg::t_in)
//  out       output     o_valid / i_stall   o_data (tbsc_pkg::t_out)
//  cfg       input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item per cycle while o_stall is low; commands are registered, via the skid under stall.
// The state update, block geometry and timeout product are done in the accept cycle.
// An output register plus a one-entry skid keep input acceptance going under output stall;
// o_stall rises only when both are full.
// Reset is synchronous, active low; configuration returns to its defaults.
module tftp_block_sender_control_top #(
    parameter int BLOCK_BYTES = tbsc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  tbsc_pkg::t_in                      i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output tbsc_pkg::t_out                     o_data,
    input  logic                               i_cfg_we,
    input  logic [tbsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tbsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int OFF_W = tbsc_pkg::IDX_W + $clog2(BLOCK_BYTES);
    localparam int CMP_W = (OFF_W + 1 > 32) ? OFF_W + 1 : 33;
    localparam logic [9:0] FULL_CNT = 10'(BLOCK_BYTES % 1024);

    // configuration
    logic [31:0] r_file_length;
    logic [15:0] r_peer_port;
    logic [7:0]  r_retry;
    logic [15:0] r_total;

    // transfer state
    logic [15:0]               r_bn, n_bn;
    logic [tbsc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [OFF_W-1:0]          r_offset, n_offset;
    logic [tbsc_pkg::TMO_W-1:0] r_tcount, n_tcount;
    logic                      r_active, n_active;

    // result buffers
    tbsc_pkg::t_out r_out, r_skid, res;
    logic           r_ov, r_sv;

    logic in_take, out_take, send;
    logic [CMP_W-1:0] len_ext, cur_sum, nx_off_ext, nx_sum, nx_rem;
    logic cur_final, nx_full, match, tmo_fail;
    logic [tbsc_pkg::PROD_W-1:0] tmo_prod;
    logic [2:0] stat;
    logic [15:0] err;

    assign in_take  = i_valid && !o_stall;
    assign out_take = r_ov && !i_stall;
    assign o_stall  = r_sv;
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    assign len_ext   = CMP_W'(r_file_length);
    assign cur_sum   = CMP_W'(r_offset) + CMP_W'(BLOCK_BYTES);
    assign cur_final = !(cur_sum <= len_ext);
    assign match     = (i_data.ack_block == r_bn) && (i_data.source_port == r_peer_port);
    assign tmo_prod  = tbsc_pkg::PROD_W'(r_tcount) * tbsc_pkg::PROD_W'(r_retry);
    assign tmo_fail  = tbsc_pkg::PROD_W'(r_total) <= tmo_prod;

    always_comb begin
        n_bn     = r_bn;
        n_idx    = r_idx;
        n_offset = r_offset;
        n_tcount = r_tcount;
        n_active = r_active;
        stat     = tbsc_pkg::ST_SEND;
        err      = '0;
        send     = 1'b1;
        if (i_data.func == tbsc_pkg::FN_START) begin
            n_bn     = tbsc_pkg::BN_FIRST;
            n_idx    = '0;
            n_offset = '0;
            n_tcount = '0;
            n_active = 1'b1;
        end else if (!r_active) begin
            stat = tbsc_pkg::ST_INACTIVE;
            send = 1'b0;
        end else begin
            case (i_data.func)
                tbsc_pkg::FN_ACK: begin
                    if (match) begin
                        if (cur_final) begin
                            n_active = 1'b0;
                            stat     = tbsc_pkg::ST_DONE;
                            send     = 1'b0;
                        end else begin
                            n_bn     = (r_bn == tbsc_pkg::BN_LAST) ? '0 : r_bn + 16'd1;
                            n_idx    = r_idx + 1'b1;
                            n_offset = (&r_idx) ? '0 : r_offset + OFF_W'(BLOCK_BYTES);
                        end
                    end
                end
                tbsc_pkg::FN_PEERERR: begin
                    n_active = 1'b0;
                    stat     = tbsc_pkg::ST_PEERERR;
                    err      = i_data.peer_error_code;
                    send     = 1'b0;
                end
                tbsc_pkg::FN_TIMEOUT: begin
                    if (tmo_fail) begin
                        n_active = 1'b0;
                        stat     = tbsc_pkg::ST_TIMEDOUT;
                        send     = 1'b0;
                    end else if (r_tcount != tbsc_pkg::TMO_MAX) begin
                        n_tcount = r_tcount + 1'b1;
                    end
                end
                tbsc_pkg::FN_RXFAIL: begin
                    n_active = 1'b0;
                    stat     = tbsc_pkg::ST_RXFAIL;
                    send     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // geometry of the block being sent, taken from the updated state
    assign nx_off_ext = CMP_W'(n_offset);
    assign nx_sum     = nx_off_ext + CMP_W'(BLOCK_BYTES);
    assign nx_full    = nx_sum <= len_ext;
    assign nx_rem     = (nx_off_ext <= len_ext) ? len_ext - nx_off_ext : '0;

    always_comb begin
        res                = '0;
        res.status         = stat;
        res.reported_error = err;
        if (send) begin
            res.send_block_number = n_bn;
            res.byte_offset       = nx_off_ext[31:0];
            res.byte_count        = nx_full ? FULL_CNT : nx_rem[9:0];
            res.final_block       = !nx_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_peer_port   <= '0;
            r_retry       <= 8'd5;
            r_total       <= 16'd25;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbsc_pkg::CFG_FILE_LENGTH:    r_file_length <= i_cfg_data;
                tbsc_pkg::CFG_PEER_PORT:      r_peer_port   <= i_cfg_data[15:0];
                tbsc_pkg::CFG_RETRY_INTERVAL: r_retry       <= i_cfg_data[7:0];
                tbsc_pkg::CFG_TOTAL_TIMEOUT:  r_total       <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bn     <= tbsc_pkg::BN_FIRST;
            r_idx    <= '0;
            r_offset <= '0;
            r_tcount <= '0;
            r_active <= 1'b0;
        end else if (in_take) begin
            r_bn     <= n_bn;
            r_idx    <= n_idx;
            r_offset <= n_offset;
            r_tcount <= n_tcount;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || out_take) begin
            r_ov <= r_sv || in_take;
            r_sv <= 1'b0;
        end else if (in_take) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || out_take) begin
            r_out <= r_sv ? r_skid : res;
        end
        if (in_take && r_ov && !out_take) begin
            r_skid <= res;
        end
    end

endmodule

// ===== src/tbsc_checker.sv =====
// Port-level checker for the TFTP block sender control, bound to the top level.
// Depends on tbsc_pkg and tftp_block_sender_control_top_assert.svh.
`include "tftp_block_sender_control_top_assert.svh"

module tbsc_checker #(
    parameter int BLOCK_BYTES = tbsc_pkg::BLOCK_BYTES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input tbsc_pkg::t_out o_data
);

    localparam logic [9:0] FULL_CNT = 10'(BLOCK_BYTES % 1024);

    `ASSERT_NXT(a_accept_gives_item, i_clk, i_rst_n, i_valid && !o_stall, o_valid)
    `ASSERT_IMP(a_nonsend_clear, i_clk, i_rst_n, o_valid && (o_data.status != tbsc_pkg::ST_SEND), (o_data.send_block_number == 16'd0) && (o_data.byte_offset == 32'd0) && (o_data.byte_count == 10'd0) && !o_data.final_block)
    `ASSERT_IMP(a_full_block, i_clk, i_rst_n, o_valid && (o_data.status == tbsc_pkg::ST_SEND) && !o_data.final_block, (o_data.byte_count == FULL_CNT) && (o_data.reported_error == 16'd0))
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

bind tftp_block_sender_control_top tbsc_checker #(
    .BLOCK_BYTES(BLOCK_BYTES)
) u_tbsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
